// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked implication checks on aclk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// File: hw/rtl/swtq_pkg.sv
// ----------------------------------------------------------------------------
// swtq_pkg
// Shared types and constants of the sorted wake-up timer queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swtq_pkg;

    localparam int unsigned PID_W   = 16;
    localparam int unsigned SEC_W   = 12;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned UNITS_W = 24;
    localparam int unsigned KIND_W  = 3;

    localparam logic [UNITS_W-1:0] UNITS_RESET = 24'd1000000;

    typedef enum logic [KIND_W-1:0] {
        KIND_QUEUED = 3'd0,
        KIND_NEG    = 3'd1,
        KIND_FULL   = 3'd2,
        KIND_WAKE   = 3'd3,
        KIND_NONE   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_INS_RD,
        ST_INS_CMP,
        ST_TICK_RD,
        ST_TICK_CMP,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] wake;
        logic [PID_W-1:0]  pid;
    } entry_t;

endpackage

// File: hw/rtl/swtq_store.sv
// ----------------------------------------------------------------------------
// swtq_store
// Entry memory of the queue: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swtq_store #(
    parameter int unsigned DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  swtq_pkg::entry_t         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output swtq_pkg::entry_t         rdata
);
    import swtq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/sorted_wakeup_timer_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_wakeup_timer_queue_top
// Wake-up queue kept in wake-time order in a circular entry memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per request. tuser[0] = op (0 sleep, 1 tick);
//   tdata = pid, seconds, now. m_ channel: one word per result, tuser = kind,
//   tdata = woken pid, tlast marks the final result of a request.
//   cfg channel: units_per_second, always ready; write only while idle.
// Sequencing (s_tready is high only while idle, between requests):
//   Sleep: multiply and add states form the wake time, then one memory
//   port pair walks back from the tail, moving each queued entry whose
//   wake time is later than the new one a slot toward the tail.
//   Rejected requests go straight to their result. A tick reads the head,
//   then releases due entries one at a time until one is not due or none is left.
// Reset: aresetn clears the queue count and head pointer and loads the
//   default units_per_second; the memory needs no clearing.
// Stall: results sit in an output register; while m_tready is low the walk
//   over due entries holds and the next request waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_wakeup_timer_queue_top #(
    parameter int unsigned QUEUE_DEPTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [swtq_pkg::UNITS_W-1:0]  cfg_data,
    // requests
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,  // pid[15:0], seconds[27:16], now[59:28]
    input  logic [0:0]                    s_tuser,  // op[0]
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,  // woken_pid[15:0]
    output logic [2:0]                    m_tuser,  // kind[2:0]
    output logic                          m_tlast
);
    import swtq_pkg::*;

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

    state_t state_reg, state_next;

    logic [UNITS_W-1:0] units_reg, units_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               m_tvalid_reg, m_tvalid_next;

    logic [PID_W-1:0]   pid_reg, pid_next;
    logic [SEC_W-1:0]   sec_reg, sec_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [TIME_W-1:0]  prod_reg, prod_next;
    logic [TIME_W-1:0]  wt_reg, wt_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [CW-1:0]      rem_reg, rem_next;
    kind_t              kind_reg, kind_next;
    logic [PID_W-1:0]   pend_pid_reg, pend_pid_next;
    logic [2:0]         m_kind_reg, m_kind_next;
    logic [PID_W-1:0]   m_pid_reg, m_pid_next;
    logic               m_last_reg, m_last_next;

    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    entry_t             mem_wdata, rd_entry;

    logic               s_fire, out_free, out_load, full;
    logic               ins_shift, tick_due;
    logic [34:0]        prod_full;
    logic [AW:0]        tail_sum;
    logic [AW-1:0]      tail_idx, pos_dec, pos_dec2, head_inc;

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] a);
        return (a == LAST_IDX) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] a);
        return (a == '0) ? LAST_IDX : a - AW'(1);
    endfunction

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign full      = (count_reg == CW'(QUEUE_DEPTH));

    assign prod_full = 35'(sec_reg[SEC_W-2:0]) * 35'(units_reg);
    assign tail_sum  = {1'b0, head_reg} + (AW + 1)'(count_reg);
    assign tail_idx  = (tail_sum >= (AW + 1)'(QUEUE_DEPTH))
                     ? AW'(tail_sum - (AW + 1)'(QUEUE_DEPTH)) : tail_sum[AW-1:0];
    assign pos_dec   = idx_dec(pos_reg);
    assign pos_dec2  = idx_dec(pos_dec);
    assign head_inc  = idx_inc(head_reg);

    assign ins_shift = rd_entry.wake > wt_reg;
    assign tick_due  = rd_entry.wake <= now_reg;

    swtq_store #(
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_entry)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    priority if (s_tuser[0]) state_next = ST_TICK_RD;
                    else if (s_tdata[27])    state_next = ST_FIN;
                    else if (full)           state_next = ST_FIN;
                    else                     state_next = ST_MUL;
                end
            end
            ST_MUL:    state_next = ST_ADD;
            ST_ADD:    state_next = ST_INS_RD;
            ST_INS_RD: begin
                state_next = (rem_reg == '0) ? ST_FIN : ST_INS_CMP;
            end
            ST_INS_CMP: begin
                if (!ins_shift) begin
                    state_next = ST_FIN;
                end else if (rem_reg == CW'(1)) begin
                    state_next = ST_INS_RD;
                end
            end
            ST_TICK_RD: begin
                state_next = (count_reg == '0) ? ST_FIN : ST_TICK_CMP;
            end
            ST_TICK_CMP: begin
                if (!tick_due) begin
                    state_next = ST_FIN;
                end else if (!pend_valid_reg || out_free) begin
                    if (count_reg == CW'(1)) state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        units_next      = (cfg_valid && cfg_ready) ? cfg_data : units_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pid_next        = pid_reg;
        sec_next        = sec_reg;
        now_next        = now_reg;
        prod_next       = prod_reg;
        wt_next         = wt_reg;
        pos_next        = pos_reg;
        rem_next        = rem_reg;
        kind_next       = kind_reg;
        pend_pid_next   = pend_pid_reg;
        out_load        = 1'b0;
        m_kind_next     = m_kind_reg;
        m_pid_next      = m_pid_reg;
        m_last_next     = m_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg;
        mem_wdata       = '{wake: wt_reg, pid: pid_reg};
        mem_re          = 1'b0;
        mem_raddr       = pos_dec;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    pid_next        = s_tdata[15:0];
                    sec_next        = s_tdata[27:16];
                    now_next        = s_tdata[59:28];
                    pend_valid_next = 1'b0;
                    priority if (s_tuser[0]) kind_next = KIND_NONE;
                    else if (s_tdata[27])    kind_next = KIND_NEG;
                    else if (full)           kind_next = KIND_FULL;
                    else                     kind_next = KIND_QUEUED;
                end
            end
            ST_MUL: begin
                prod_next = prod_full[TIME_W-1:0];
            end
            ST_ADD: begin
                wt_next  = now_reg + prod_reg;
                pos_next = tail_idx;
                rem_next = count_reg;
            end
            ST_INS_RD: begin
                if (rem_reg == '0) begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                end else begin
                    mem_re = 1'b1;
                end
            end
            ST_INS_CMP: begin
                mem_we = 1'b1;
                if (ins_shift) begin
                    // move the later entry one slot toward the tail
                    mem_wdata = rd_entry;
                    pos_next  = pos_dec;
                    rem_next  = rem_reg - CW'(1);
                    if (rem_reg != CW'(1)) begin
                        mem_re    = 1'b1;
                        mem_raddr = pos_dec2;
                    end
                end else begin
                    count_next = count_reg + CW'(1);
                end
            end
            ST_TICK_RD: begin
                mem_raddr = head_reg;
                mem_re    = (count_reg != '0);
            end
            ST_TICK_CMP: begin
                mem_raddr = head_inc;
                if (tick_due && (!pend_valid_reg || out_free)) begin
                    // emit the held entry, hold this one until its successor is known
                    if (pend_valid_reg) begin
                        out_load    = 1'b1;
                        m_kind_next = KIND_WAKE;
                        m_pid_next  = pend_pid_reg;
                        m_last_next = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_pid_next   = rd_entry.pid;
                    head_next       = head_inc;
                    count_next      = count_reg - CW'(1);
                    // fetch the new head
                    if (count_reg != CW'(1)) begin
                        mem_re = 1'b1;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    m_kind_next = pend_valid_reg ? KIND_WAKE : kind_reg;
                    m_pid_next  = pend_valid_reg ? pend_pid_reg : '0;
                    m_last_next = 1'b1;
                end
            end
            default: ;
        endcase

        m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            units_reg      <= UNITS_RESET;
            head_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            units_reg      <= units_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pid_reg      <= pid_next;
        sec_reg      <= sec_next;
        now_reg      <= now_next;
        prod_reg     <= prod_next;
        wt_reg       <= wt_next;
        pos_reg      <= pos_next;
        rem_reg      <= rem_next;
        kind_reg     <= kind_next;
        pend_pid_reg <= pend_pid_next;
        m_kind_reg   <= m_kind_next;
        m_pid_reg    <= m_pid_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_pid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: hw/rtl/swtq_checker.sv
// ----------------------------------------------------------------------------
// swtq_checker
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swtq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    import swtq_pkg::*;

    // only wake results carry a process id
    `AST_SAME(a_pid_zero, m_tvalid && (m_tuser != KIND_WAKE), m_tdata == '0)
    // every result other than a wake ends its request
    `AST_SAME(a_single_last, m_tvalid && (m_tuser != KIND_WAKE), m_tlast)
    // a taken request occupies the block for at least the next cycle
    `AST_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // a stalled result word holds
    `AST_NEXT(a_out_hold, m_tvalid && !m_tready,
              m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind sorted_wakeup_timer_queue_top swtq_checker u_swtq_checker (.*);
